[design/i2cbs_pkg.sv]
// Package for the I2C master bit sequencer: command codes, queue sizing,
// and the packed types of the input command, the queued command and the pin event.
// No dependencies.
`default_nettype none

package i2cbs_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] LAST_STEP_START = 5'd0;
    localparam logic [STEP_W-1:0] LAST_STEP_BYTE  = 5'd17;
    localparam logic [STEP_W-1:0] LAST_STEP_STOP  = 5'd3;
    localparam logic [STEP_W-1:0] ACK_LOW_STEP    = 5'd16;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = 1;
    localparam int CMD_CNT_W      = 2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] out_byte;
        logic       ack_to_send;
        logic [8:0] sda_samples;
    } command_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data;
        logic              ack_bit;
        logic [STEP_W-1:0] last_step;
    } cmd_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       last;
    } pin_event_t;

endpackage

`default_nettype wire

[design/i2cbs_front.sv]
// Front stage of the I2C master bit sequencer: accepts commands and classifies them.
// Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_front
    import i2cbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire command_t command,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic load;

    assign full      = valid_reg && !cmd_ready;
    assign load      = push && !full;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next.kind = command.op;
        unique case (command.op)
            OP_START:
            begin
                cmd_next.data      = 8'd0;
                cmd_next.ack_bit   = 1'b0;
                cmd_next.last_step = LAST_STEP_START;
            end
            OP_WRITE:
            begin
                cmd_next.data      = command.out_byte;
                cmd_next.ack_bit   = command.sda_samples[0];
                cmd_next.last_step = LAST_STEP_BYTE;
            end
            OP_READ:
            begin
                cmd_next.data      = command.sda_samples[8:1];
                cmd_next.ack_bit   = command.ack_to_send;
                cmd_next.last_step = LAST_STEP_BYTE;
            end
            default:
            begin
                cmd_next.data      = 8'd0;
                cmd_next.ack_bit   = 1'b0;
                cmd_next.last_step = LAST_STEP_STOP;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

[design/i2cbs_cmd_fifo.sv]
// Two-entry command queue between the front and back stages of the sequencer.
// Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_cmd_fifo
    import i2cbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire cmd_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_data
);

    cmd_t                 mem [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign wr_ready = (count_reg != CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[design/i2cbs_back.sv]
// Back stage of the I2C master bit sequencer: steps through the pin events of
// the queued command, holds the bus pin state and the result register. Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_back
    import i2cbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_pop,
    input  wire cmd_t cmd,
    output logic      empty,
    input  wire logic pop,
    output pin_event_t pin_state
);

    logic              scl_reg;
    logic              sda_reg;
    logic              drive_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    pin_event_t        out_reg;
    pin_event_t        ev;
    logic              advance;
    logic [2:0]        bit_idx;

    assign advance   = cmd_valid && (!out_valid_reg || pop);
    assign bit_idx   = ~step_reg[3:1];
    assign empty     = !out_valid_reg;
    assign pin_state = out_reg;

    always_comb
    begin
        ev.scl_level = scl_reg;
        ev.sda_level = sda_reg;
        ev.sda_drive = drive_reg;
        ev.read_byte = 8'd0;
        ev.ack_seen  = 1'b0;
        ev.last      = (step_reg == cmd.last_step);
        unique case (cmd.kind)
            OP_START:
            begin
                ev.sda_level = 1'b0;
                ev.sda_drive = 1'b1;
            end
            OP_WRITE:
            begin
                if (step_reg[0])
                begin
                    ev.scl_level = 1'b1;
                    ev.ack_seen  = ev.last ? cmd.ack_bit : 1'b0;
                end
                else if (step_reg == ACK_LOW_STEP)
                begin
                    ev.scl_level = 1'b0;
                    ev.sda_drive = 1'b0;
                end
                else
                begin
                    ev.scl_level = 1'b0;
                    ev.sda_level = cmd.data[bit_idx];
                    ev.sda_drive = 1'b1;
                end
            end
            OP_READ:
            begin
                if (step_reg[0])
                begin
                    ev.scl_level = 1'b1;
                    ev.read_byte = ev.last ? cmd.data : 8'd0;
                end
                else if (step_reg == ACK_LOW_STEP)
                begin
                    ev.scl_level = 1'b0;
                    ev.sda_level = cmd.ack_bit;
                    ev.sda_drive = 1'b1;
                end
                else
                begin
                    ev.scl_level = 1'b0;
                    ev.sda_drive = 1'b0;
                end
            end
            default:
            begin
                unique case (step_reg[1:0])
                    2'd0:
                    begin
                        ev.scl_level = 1'b0;
                    end
                    2'd1:
                    begin
                        ev.sda_level = 1'b0;
                        ev.sda_drive = 1'b1;
                    end
                    2'd2:
                    begin
                        ev.scl_level = 1'b1;
                    end
                    default:
                    begin
                        ev.sda_level = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        cmd_pop        = advance && ev.last;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            step_next      = ev.last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                scl_reg   <= ev.scl_level;
                sda_reg   <= ev.sda_level;
                drive_reg <= ev.sda_drive;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= ev;
        end
    end

endmodule

`default_nettype wire

[design/i2c_master_bit_sequencer.sv]
// Top level of the I2C master bit sequencer: front stage, command queue and back stage.
// Depends on i2cbs_pkg, i2cbs_front, i2cbs_cmd_fifo and i2cbs_back.
//
// Usage:
// Commands (start, write byte, read byte, stop) enter on the command port as a
// queue: a transaction is taken when push is high and full is low. Pin events
// leave on pin_state as a queue: the oldest event is shown while empty is low
// and is taken when pop is high and empty is low. Each event gives SCL, the SDA
// latch and the SDA drive enable after it; the last event of a command has
// last set and carries the read byte or the sampled ACK.
// A start gives 1 event, a stop 4, a write or read 18, one event per cycle while
// pop stays high and a command is queued. The back stage's event stepper steps
// a command to its last event before it pops the next from the queue. A command
// passes the front register and a queue entry before its events reach the result register.
// The front register and a two-entry queue keep taking commands while the
// receiver stalls; the command being stepped stays at the head of the queue,
// so full rises once the front register and both queue entries hold commands.
// Reset drops all queued work and sets SCL high, the SDA latch high, SDA released.
`default_nettype none

module i2c_master_bit_sequencer
    import i2cbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire command_t command,
    output logic          empty,
    input  wire logic     pop,
    output pin_event_t    pin_state
);

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_pop;
    cmd_t queue_cmd;

    i2cbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    i2cbs_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_cmd),
        .rd_valid (queue_valid),
        .rd_ready (queue_pop),
        .rd_data  (queue_cmd)
    );

    i2cbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_pop   (queue_pop),
        .cmd       (queue_cmd),
        .empty     (empty),
        .pop       (pop),
        .pin_state (pin_state)
    );

endmodule

`default_nettype wire
